@@ src/fmm_pkg.sv @@
// ----------------------------------------------------------------------------
// fmm_pkg: shared types and constants for the float matrix multiply block
// Beat structs, function codes, register indexes and state encodings.
// ----------------------------------------------------------------------------
package fmm_pkg;

  localparam int MaxDimDefault = 8;

  // Function codes of an input beat
  localparam logic [1:0] FuncLoadA = 2'd0;
  localparam logic [1:0] FuncLoadB = 2'd1;
  localparam logic [1:0] FuncStart = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CfgRowsM  = 2'd0;
  localparam logic [1:0] CfgColsN  = 2'd1;
  localparam logic [1:0] CfgInnerK = 2'd2;

  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  row_index;
    logic [2:0]  col_index;
    logic [31:0] elem_bits;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  out_row;
    logic [2:0]  out_col;
    logic [31:0] out_bits;
    logic        last;
  } out_beat_t;

  typedef enum logic {
    FPU_MUL,
    FPU_ADD
  } fpu_op_e;

  typedef struct packed {
    logic    start;
    fpu_op_e op;
  } fpu_req_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_NORM,
    F_DENORM,
    F_ROUND
  } fpu_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_MWAIT,
    S_ADD,
    S_AWAIT,
    S_OUT
  } seq_state_e;

endpackage

@@ src/fmm_fpu.sv @@
// ----------------------------------------------------------------------------
// fmm_fpu: shared binary32 multiply / add unit
// Multi-cycle unit: operate, normalize a few bits per cycle, denormalize,
// round to nearest even. NaN results come out as the canonical quiet NaN.
// ----------------------------------------------------------------------------
module fmm_fpu
  import fmm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fpu_req_t    req_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] result_o
);

  fpu_state_e         state_q, state_d;
  logic               sign_q;
  logic signed [10:0] exp_q;
  logic [47:0]        man_q;
  logic [31:0]        res_q;
  logic               done_q;

  // Operand decode
  logic        sa, sb;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        za, zb, ia, ib, na, nb;

  always_comb begin
    sa = a_i[31];
    sb = b_i[31];
    ea = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma = {a_i[30:23] != 8'd0, a_i[22:0]};
    mb = {b_i[30:23] != 8'd0, b_i[22:0]};
    za = a_i[30:0] == 31'd0;
    zb = b_i[30:0] == 31'd0;
    ia = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    ib = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    na = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    nb = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
  end

  // First step: special operands, or the raw product / aligned sum
  logic               spec;
  logic [31:0]        spec_res;
  logic               ld_sign;
  logic signed [10:0] ld_exp;
  logic [47:0]        ld_man;

  logic        swap, sx, sy;
  logic [7:0]  ex, ey, dexp;
  logic [23:0] mx, my;
  logic [26:0] xf, yf, yal;
  logic [27:0] sum;
  logic        smul;

  always_comb begin
    spec     = 1'b0;
    spec_res = 32'd0;
    ld_sign  = 1'b0;
    ld_exp   = 11'sd0;
    ld_man   = 48'd0;
    smul     = sa ^ sb;
    swap     = a_i[30:0] < b_i[30:0];
    sx       = swap ? sb : sa;
    sy       = swap ? sa : sb;
    ex       = swap ? eb : ea;
    ey       = swap ? ea : eb;
    mx       = swap ? mb : ma;
    my       = swap ? ma : mb;
    dexp     = ex - ey;
    xf       = {mx, 3'b000};
    yf       = {my, 3'b000};
    if (dexp >= 8'd27) begin
      yal = 27'd1;
    end else begin
      yal = (yf >> dexp) | 27'(|(yf & ((27'd1 << dexp) - 27'd1)));
    end
    sum = (sx != sy) ? ({1'b0, xf} - {1'b0, yal}) : ({1'b0, xf} + {1'b0, yal});

    if (req_i.op == FPU_MUL) begin
      if (na || nb || (ia && zb) || (za && ib)) begin
        spec     = 1'b1;
        spec_res = CanonNan;
      end else if (ia || ib) begin
        spec     = 1'b1;
        spec_res = {smul, 8'hFF, 23'd0};
      end else if (za || zb) begin
        spec     = 1'b1;
        spec_res = {smul, 31'd0};
      end else begin
        ld_sign = smul;
        ld_man  = ma * mb;
        ld_exp  = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
      end
    end else begin
      if (na || nb || (ia && ib && (sa != sb))) begin
        spec     = 1'b1;
        spec_res = CanonNan;
      end else if (ia) begin
        spec     = 1'b1;
        spec_res = a_i;
      end else if (ib) begin
        spec     = 1'b1;
        spec_res = b_i;
      end else if (za && zb) begin
        spec     = 1'b1;
        spec_res = {sa & sb, 31'd0};
      end else if (za) begin
        spec     = 1'b1;
        spec_res = b_i;
      end else if (zb) begin
        spec     = 1'b1;
        spec_res = a_i;
      end else if (sum == 28'd0) begin
        spec     = 1'b1;
        spec_res = 32'd0;
      end else begin
        ld_sign = sx;
        ld_man  = {sum, 20'd0};
        ld_exp  = $signed({3'b000, ex}) + 11'sd1;
      end
    end
  end

  // Denormalize shift for results below the normal range
  logic [10:0] dshift;
  logic [47:0] dman;

  always_comb begin
    dshift = 11'(11'sd1 - exp_q);
    if (dshift >= 11'd48) begin
      dman = 48'(|man_q);
    end else begin
      dman = (man_q >> dshift) | 48'(|(man_q & ((48'd1 << dshift) - 48'd1)));
    end
  end

  // Round to nearest even; a carry ripples into the exponent field
  logic        rnd_up;
  logic [31:0] rnd_res;

  always_comb begin
    rnd_up = man_q[23] & ((|man_q[22:0]) | man_q[24]);
    if (exp_q > 11'sd254) begin
      rnd_res = {sign_q, 8'hFF, 23'd0};
    end else begin
      rnd_res = {sign_q, 31'({exp_q[7:0], man_q[46:24]} + 31'(rnd_up))};
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:   if (req_i.start && !spec) state_d = F_NORM;
      F_NORM:   if (man_q[47]) state_d = F_DENORM;
      F_DENORM: state_d = F_ROUND;
      F_ROUND:  state_d = F_IDLE;
      default:  state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == F_IDLE) && req_i.start && spec) || (state_q == F_ROUND);
    end
  end

  // Datapath: load, shift left up to four bits a cycle, shift right, round
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      F_IDLE: begin
        if (req_i.start) begin
          sign_q <= ld_sign;
          exp_q  <= ld_exp;
          man_q  <= ld_man;
          res_q  <= spec_res;
        end
      end
      F_NORM: begin
        if (!man_q[47]) begin
          if (man_q[47:44] == 4'd0) begin
            man_q <= man_q << 4;
            exp_q <= exp_q - 11'sd4;
          end else begin
            man_q <= man_q << 1;
            exp_q <= exp_q - 11'sd1;
          end
        end
      end
      F_DENORM: begin
        if (exp_q < 11'sd1) begin
          man_q <= dman;
          exp_q <= 11'sd0;
        end
      end
      F_ROUND: res_q <= rnd_res;
      default: res_q <= res_q;
    endcase
  end

  // Outputs
  always_comb begin
    done_o   = done_q;
    result_o = res_q;
  end

endmodule

@@ src/float_matrix_multiply.sv @@
// ----------------------------------------------------------------------------
// float_matrix_multiply: binary32 C = A x B over stored operand matrices
// Loads A and B elements into local stores, then streams the result matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): a load beat writes
//   one element of A or B at (row, column). A start beat runs the whole
//   product; the input stalls until the last result beat has been taken.
//   Output channel (out_valid_o / out_stall_i / out_data_o): one beat per
//   result element, row-major, last set on the final one. A stalled beat
//   holds and the sequencer waits.
//   Config channel (cfg_valid_i / cfg_ready_o): rows_m, cols_n, inner_k;
//   write only while idle. Zero acts as one, above MAX_DIM as MAX_DIM.
//   Sequence: each term of a dot product costs a store read state, one issue
//   state plus one pass through the shared floating-point unit for the
//   multiply, and the same for the add. A pass for a special operand skips
//   normalization and rounding; else its length depends on normalization.
//   Each result adds an output state; a run is M*N of those with K terms.
//   Reset returns registers to 8 and the sequencer to idle; the stores are
//   not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module float_matrix_multiply
  import fmm_pkg::*;
#(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [3:0] cfg_data_i
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  seq_state_e  state_q, state_d;
  logic [3:0]  rows_q, cols_q, inner_q;
  logic [3:0]  m_eff, n_eff, k_eff;
  logic [3:0]  i_q, j_q, k_q;
  logic [31:0] acc_q, prod_q;
  logic [31:0] a_rd_q, b_rd_q;
  logic        out_valid_q;
  out_beat_t   out_q;
  fpu_req_t    fpu_req;
  logic [31:0] fpu_a, fpu_b, fpu_res;
  logic        fpu_done;

  logic [31:0] a_mem [Depth];
  logic [31:0] b_mem [Depth];

  logic          in_acc, ld_ok, k_last, last_elem, out_take;
  logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;

  // Clamp the configured dimensions
  always_comb begin
    m_eff = (rows_q == 4'd0) ? 4'd1 : ((int'(rows_q) > MAX_DIM) ? 4'(MAX_DIM) : rows_q);
    n_eff = (cols_q == 4'd0) ? 4'd1 : ((int'(cols_q) > MAX_DIM) ? 4'(MAX_DIM) : cols_q);
    k_eff = (inner_q == 4'd0) ? 4'd1 : ((int'(inner_q) > MAX_DIM) ? 4'(MAX_DIM) : inner_q);
  end

  assign in_acc    = in_valid_i && !in_stall_o;
  assign ld_ok     = (int'(in_data_i.row_index) < MAX_DIM) && (int'(in_data_i.col_index) < MAX_DIM);
  assign wr_addr   = AW'(int'(in_data_i.row_index) * MAX_DIM + int'(in_data_i.col_index));
  assign rd_addr_a = AW'(int'(i_q) * MAX_DIM + int'(k_q));
  assign rd_addr_b = AW'(int'(k_q) * MAX_DIM + int'(j_q));
  assign k_last    = (k_q + 4'd1) == k_eff;
  assign last_elem = ((i_q + 4'd1) == m_eff) && ((j_q + 4'd1) == n_eff);
  assign out_take  = out_valid_q && !out_stall_i;

  // Operand stores
  always_ff @(posedge clk_i) begin
    if (in_acc && ld_ok && (in_data_i.func == FuncLoadA)) a_mem[wr_addr] <= in_data_i.elem_bits;
    if (in_acc && ld_ok && (in_data_i.func == FuncLoadB)) b_mem[wr_addr] <= in_data_i.elem_bits;
    a_rd_q <= a_mem[rd_addr_a];
    b_rd_q <= b_mem[rd_addr_b];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc && (in_data_i.func == FuncStart)) state_d = S_READ;
      S_READ:  state_d = S_MUL;
      S_MUL:   state_d = S_MWAIT;
      S_MWAIT: if (fpu_done) state_d = S_ADD;
      S_ADD:   state_d = S_AWAIT;
      S_AWAIT: if (fpu_done) state_d = k_last ? S_OUT : S_READ;
      S_OUT:   if (out_take) state_d = last_elem ? S_IDLE : S_READ;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    fpu_req.start = (state_q == S_MUL) || (state_q == S_ADD);
    fpu_req.op    = (state_q == S_ADD) ? FPU_ADD : FPU_MUL;
    fpu_a         = (state_q == S_ADD) ? acc_q : a_rd_q;
    fpu_b         = (state_q == S_ADD) ? prod_q : b_rd_q;
    in_stall_o    = state_q != S_IDLE;
    cfg_ready_o   = 1'b1;
    out_valid_o   = out_valid_q;
    out_data_o    = out_q;
  end

  fmm_fpu u_fpu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (fpu_req),
    .a_i      (fpu_a),
    .b_i      (fpu_b),
    .done_o   (fpu_done),
    .result_o (fpu_res)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rows_q      <= 4'd8;
      cols_q      <= 4'd8;
      inner_q     <= 4'd8;
      out_valid_q <= 1'b0;
      i_q         <= 4'd0;
      j_q         <= 4'd0;
      k_q         <= 4'd0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgRowsM:  rows_q  <= cfg_data_i;
          CfgColsN:  cols_q  <= cfg_data_i;
          CfgInnerK: inner_q <= cfg_data_i;
          default:   rows_q  <= rows_q;
        endcase
      end
      // Advance the loop counters
      if (state_q == S_IDLE) begin
        i_q <= 4'd0;
        j_q <= 4'd0;
        k_q <= 4'd0;
      end else if ((state_q == S_AWAIT) && fpu_done) begin
        out_valid_q <= k_last;
        k_q         <= k_last ? 4'd0 : k_q + 4'd1;
      end else if ((state_q == S_OUT) && out_take) begin
        out_valid_q <= 1'b0;
        if ((j_q + 4'd1) == n_eff) begin
          j_q <= 4'd0;
          i_q <= i_q + 4'd1;
        end else begin
          j_q <= j_q + 4'd1;
        end
      end
    end
  end

  // Accumulator, product and result beat
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE || ((state_q == S_OUT) && out_take)) acc_q <= 32'd0;
    if ((state_q == S_MWAIT) && fpu_done) prod_q <= fpu_res;
    if ((state_q == S_AWAIT) && fpu_done) begin
      acc_q          <= fpu_res;
      out_q.out_row  <= i_q[2:0];
      out_q.out_col  <= j_q[2:0];
      out_q.out_bits <= fpu_res;
      out_q.last     <= last_elem;
    end
  end

  // Checks
  a_valid_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == S_OUT))
    else $error("result beat outside output state");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input open while a result is pending");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last) |=> !in_stall_o)
    else $error("sequencer did not return to idle after last beat");

  a_fpu_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fpu_done |-> (state_q == S_MWAIT || state_q == S_AWAIT))
    else $error("unexpected arithmetic completion");

endmodule

@@ sim/fmm_checker.sv @@
// ----------------------------------------------------------------------------
// fmm_checker: result predictor and scoreboard for float_matrix_multiply
// Watches the load, config and result channels. Keeps its own copy of the
// operand stores and dimensions, computes each result with bit-exact binary32
// multiply and add, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module fmm_checker
  import fmm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_beat_t   in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_beat_t  out_data_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_index_i,
  input  logic [3:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         result_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Dim = MaxDimDefault;

  logic [31:0] a_mat [Dim*Dim];
  logic [31:0] b_mat [Dim*Dim];
  logic [3:0]  rows_q, cols_q, inner_q;
  out_beat_t   product_q [$];

  assign pending_o = product_q.size();

  function automatic int eff_dim(logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > Dim) return Dim;
    return int'(v);
  endfunction

  function automatic logic is_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  // Split into integer significand and exponent of its lsb
  function automatic void split(input logic [31:0] x, output longint unsigned m,
                                output int e);
    m = (x[30:23] != 8'd0) ? {40'd1, x[22:0]} : {41'd0, x[22:0]};
    e = ((x[30:23] != 8'd0) ? int'(x[30:23]) : 1) - 150;
  endfunction

  // Round mag * 2^e to nearest-even binary32, subnormals and overflow included
  function automatic logic [31:0] round_pack(logic sgn, longint unsigned mag, int e);
    int p;
    int s;
    longint unsigned r;
    longint unsigned rem;
    longint unsigned half;
    longint bits;
    if (mag == 0) return {sgn, 31'd0};
    p = 63;
    while (!mag[p]) p--;
    s = p - 23;
    if (s < -149 - e) s = -149 - e;
    if (s > 64) begin
      r = 0;
    end else if (s > 0) begin
      r = mag >> s;
      rem = mag & ((64'd1 << s) - 64'd1);
      half = 64'd1 << (s - 1);
      if (rem > half || (rem == half && r[0])) r++;
    end else begin
      r = mag << (-s);
    end
    bits = (s > 64) ? 0 : (longint'(e + s + 149) <<< 23) + longint'(r);
    if (bits >= 64'h7F80_0000) return {sgn, 8'hFF, 23'd0};
    return {sgn, bits[30:0]};
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] x, logic [31:0] y);
    logic sgn;
    longint unsigned mx, my;
    int ex, ey;
    if (is_nan(x) || is_nan(y)) return CanonNan;
    sgn = x[31] ^ y[31];
    if (is_inf(x) || is_inf(y)) begin
      if (x[30:0] == 31'd0 || y[30:0] == 31'd0) return CanonNan;
      return {sgn, 8'hFF, 23'd0};
    end
    split(x, mx, ex);
    split(y, my, ey);
    return round_pack(sgn, mx * my, ex + ey);
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] x, logic [31:0] y);
    longint unsigned mx, my, big, little;
    int ex, ey, d, e;
    logic sb, sl;
    longint sum;
    if (is_nan(x) || is_nan(y)) return CanonNan;
    if (is_inf(x) && is_inf(y)) return (x[31] == y[31]) ? x : CanonNan;
    if (is_inf(x)) return x;
    if (is_inf(y)) return y;
    split(x, mx, ex);
    split(y, my, ey);
    if (mx == 0 && my == 0) return {x[31] & y[31], 31'd0};
    if (ex >= ey) begin
      big = mx; little = my; sb = x[31]; sl = y[31]; d = ex - ey; e = ey;
    end else begin
      big = my; little = mx; sb = y[31]; sl = x[31]; d = ey - ex; e = ex;
    end
    // Align exactly when close, else fold the far-off bits into a sticky lsb
    if (d <= 38) begin
      big = big << d;
    end else begin
      big = big << 38;
      e = e + d - 38;
      if (d - 38 >= 64) little = (little != 0);
      else little = (little >> (d - 38)) |
                    (((little & ((64'd1 << (d - 38)) - 64'd1)) != 0) ? 64'd1 : 64'd0);
    end
    sum = (sb ? -longint'(big) : longint'(big)) + (sl ? -longint'(little) : longint'(little));
    if (sum == 0) return 32'd0;
    return round_pack(sum < 0, (sum < 0) ? longint'(-sum) : sum, e);
  endfunction

  // Queue every element of the product, row-major, flagging the final one
  task automatic predict_product();
    int m, n, k;
    logic [31:0] acc;
    out_beat_t beat;
    m = eff_dim(rows_q);
    n = eff_dim(cols_q);
    k = eff_dim(inner_q);
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = 32'd0;
        for (int t = 0; t < k; t++) begin
          acc = fp_add(acc, fp_mul(a_mat[i*Dim+t], b_mat[t*Dim+j]));
        end
        if (is_nan(acc)) acc = CanonNan;
        beat.out_row = 3'(i);
        beat.out_col = 3'(j);
        beat.out_bits = acc;
        beat.last = (i == m - 1) && (j == n - 1);
        product_q.push_back(beat);
      end
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h (result %0d)", what, got, want,
             result_count_o);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      rows_q = 4'd8;
      cols_q = 4'd8;
      inner_q = 4'd8;
      product_q.delete();
      fail_count_o = 0;
      result_count_o = 0;
    end else begin
      // Track register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgRowsM: rows_q = cfg_data_i;
          CfgColsN: cols_q = cfg_data_i;
          CfgInnerK: inner_q = cfg_data_i;
          default: ;
        endcase
      end
      // Check a taken result beat against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (product_q.size() == 0) begin
          report("unexpected beat", out_data_i.out_bits, 32'd0);
        end else begin
          want = product_q.pop_front();
          if (out_data_i.out_row !== want.out_row)
            report("out_row", 32'(out_data_i.out_row), 32'(want.out_row));
          if (out_data_i.out_col !== want.out_col)
            report("out_col", 32'(out_data_i.out_col), 32'(want.out_col));
          if (out_data_i.out_bits !== want.out_bits)
            report("out_bits", out_data_i.out_bits, want.out_bits);
          if (out_data_i.last !== want.last)
            report("last", 32'(out_data_i.last), 32'(want.last));
        end
        result_count_o++;
      end
      // Apply an accepted input beat
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.func)
          FuncLoadA: a_mat[in_data_i.row_index*Dim + in_data_i.col_index] = in_data_i.elem_bits;
          FuncLoadB: b_mat[in_data_i.row_index*Dim + in_data_i.col_index] = in_data_i.elem_bits;
          FuncStart: predict_product();
          default: ;
        endcase
      end
    end
  end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: regression bench for float_matrix_multiply
// Loads operand elements, starts products over many dimension settings and
// special float values, with random idling on both channels and one long
// output hold-off. The checker predicts and scores every result beat.
// ----------------------------------------------------------------------------
module tb;
  import fmm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2_000_000;
  localparam int ItemTarget = 230;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  in_beat_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_beat_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  int fail_count, pending, result_count;
  int cycles = 0;
  int items = 0;
  int products = 0;
  int phase = 0;
  logic hold_req = 1'b0;
  int hold_cnt = 0;
  logic held_once = 1'b0;
  logic [3:0] dm, dn, dk;

  float_matrix_multiply uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  fmm_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("float_matrix_multiply regression: fail");
      $finish;
    end
  end

  // Drive result stall: long hold-off on request, else random per phase
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      case (phase)
        0: out_stall <= ($urandom_range(99) < 79);
        1: out_stall <= ($urandom_range(99) < 29);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  function automatic int eff_dim(logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > MaxDimDefault) return MaxDimDefault;
    return int'(v);
  endfunction

  // Mix of special encodings and ordinary magnitudes
  function automatic logic [31:0] rand_elem();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(11))
      0: return {v[31], 31'd0};
      1: return {v[31], 8'hFF, 23'd0};
      2: return {v[31], 8'hFF, v[22:1], 1'b1};
      3: return {v[31], 8'd0, v[22:0]};
      4: return {v[31], 31'h7F7F_FFFF};
      5: return {v[31], 8'd1, v[22:0]};
      6: return v;
      default: return {v[31], 8'(110 + $urandom_range(34)), v[22:0]};
    endcase
  endfunction

  // Offer one input beat and hold it until taken; valid stays high afterward
  task automatic send_beat(logic [1:0] func, logic [2:0] row, logic [2:0] col,
                           logic [31:0] bits);
    int idle_pct;
    idle_pct = (phase == 0) ? 29 : (phase == 1) ? 79 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{func: func, row_index: row, col_index: col, elem_bits: bits};
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    items++;
    if (func == FuncStart) products++;
    phase = (items < 80) ? 0 : (items < 160) ? 1 : 2;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
  endtask

  // Drain, let the block settle, then write all three dimensions
  task automatic set_dims(logic [3:0] m, logic [3:0] n, logic [3:0] k);
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    write_reg(CfgRowsM, m);
    write_reg(CfgColsN, n);
    write_reg(CfgInnerK, k);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [3:0] pick_dim();
    case ($urandom_range(9))
      0: return 4'd0;
      1: return 4'd15;
      2: return 4'd8;
      default: return 4'($urandom_range(1, 3));
    endcase
  endfunction

  // One full product: load every operand it reads, some noise, then start
  task automatic run_product(logic [3:0] m, logic [3:0] n, logic [3:0] k, logic hold);
    int em, en, ek;
    em = eff_dim(m);
    en = eff_dim(n);
    ek = eff_dim(k);
    set_dims(m, n, k);
    for (int i = 0; i < em; i++)
      for (int t = 0; t < ek; t++) send_beat(FuncLoadA, 3'(i), 3'(t), rand_elem());
    for (int t = 0; t < ek; t++)
      for (int j = 0; j < en; j++) send_beat(FuncLoadB, 3'(t), 3'(j), rand_elem());
    repeat ($urandom_range(2)) begin
      if ($urandom_range(1)) send_beat(2'd3, 3'($urandom), 3'($urandom), $urandom);
      else send_beat(2'($urandom_range(1)), 3'($urandom), 3'($urandom), rand_elem());
    end
    if (hold) hold_req = 1'b1;
    send_beat(FuncStart, 3'($urandom), 3'($urandom), $urandom);
    // Keep offering a beat while the output is held off so the input stalls
    if (hold) send_beat(2'd3, 3'($urandom), 3'($urandom), $urandom);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CfgRowsM;
    cfg_data = 4'd0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: overflow, inf times zero, NaN payload, subnormal underflow
    set_dims(4'd1, 4'd1, 4'd1);
    send_beat(FuncLoadA, 3'd0, 3'd0, 32'h7F7F_FFFF);
    send_beat(FuncLoadB, 3'd0, 3'd0, 32'h4000_0000);
    send_beat(FuncStart, 3'd0, 3'd0, 32'd0);
    send_beat(FuncLoadA, 3'd0, 3'd0, 32'hFF80_0000);
    send_beat(FuncLoadB, 3'd0, 3'd0, 32'h8000_0000);
    send_beat(FuncStart, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_beat(FuncLoadA, 3'd0, 3'd0, 32'hFFFF_FFFF);
    send_beat(FuncStart, 3'd0, 3'd0, 32'd0);
    send_beat(FuncLoadA, 3'd0, 3'd0, 32'h0000_0001);
    send_beat(FuncLoadB, 3'd0, 3'd0, 32'h3F00_0000);
    send_beat(FuncStart, 3'd0, 3'd0, 32'd0);
    send_beat(2'd3, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_beat(FuncLoadA, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_beat(FuncLoadB, 3'd7, 3'd7, 32'h0000_0000);
    send_beat(FuncLoadA, 3'd0, 3'd0, 32'h8000_0000);
    send_beat(FuncStart, 3'd0, 3'd0, 32'd0);
    // Zero and over-range dimensions clamp
    run_product(4'd0, 4'd15, 4'd0, 1'b0);
    run_product(4'd15, 4'd1, 4'd1, 1'b0);

    // Random products over the three idling phases, one long hold-off
    while (items < ItemTarget) begin
      dm = pick_dim();
      dn = pick_dim();
      dk = pick_dim();
      // Shrink products near the end so the beat count lands close to target
      if (items + eff_dim(dm) * eff_dim(dk) + eff_dim(dk) * eff_dim(dn) > ItemTarget) begin
        dm = 4'd1;
        dn = 4'd1;
        dk = 4'd1;
      end
      run_product(dm, dn, dk, phase == 2 && !held_once);
      if (phase == 2) held_once = 1'b1;
    end

    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);

    $display("covered %0d input beats, %0d products, %0d result beats in %0d cycles",
             items, products, result_count, cycles);
    $display("dimensions 0..15 incl. clamping, special floats, idling on both sides");
    if (fail_count == 0) begin
      $display("float_matrix_multiply regression: pass");
    end else begin
      $display("float_matrix_multiply regression: fail");
    end
    $finish;
  end

endmodule
